@@ hw/rtl/ckas_pkg.sv @@
// ----------------------------------------------------------------------------
// ckas_pkg
// Types and constants shared by the clock alarm set controller.
// ----------------------------------------------------------------------------
package ckas_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned PADDR_W   = 4;
	localparam int unsigned IN_DATA_W = 32;
	localparam int unsigned OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_CLOCK     = 2'd0,
		MODE_TEMP      = 2'd1,
		MODE_SET_CLOCK = 2'd2,
		MODE_SET_ALARM = 2'd3
	} mode_t;

	localparam logic [1:0] CUR_HOUR   = 2'd0;
	localparam logic [1:0] CUR_MINUTE = 2'd1;
	localparam logic [1:0] CUR_SECOND = 2'd2;

	localparam logic [7:0] KEY_DEC       = 8'd4;
	localparam logic [7:0] KEY_UP        = 8'd5;
	localparam logic [7:0] KEY_SET_ALARM = 8'd6;
	localparam logic [7:0] KEY_SET_CLOCK = 8'd7;

	localparam logic [1:0] REG_BLINK_PERIOD = 2'd0;
	localparam logic [1:0] REG_ALARM_TOGGLE = 2'd1;
	localparam logic [1:0] REG_ALARM_LENGTH = 2'd2;

	localparam logic [7:0] RST_BLINK_PERIOD = 8'd10;
	localparam logic [7:0] RST_ALARM_TOGGLE = 8'd4;
	localparam logic [9:0] RST_ALARM_LENGTH = 10'd100;

	localparam logic [5:0] HOUR_MAX = 6'd23;
	localparam logic [5:0] MIN_MAX  = 6'd59;
	localparam logic [9:0] ELAPSED_MAX = 10'd1023;

	typedef struct packed {
		logic [7:0] blink_period;
		logic [7:0] alarm_toggle;
		logic [9:0] alarm_length;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] key_code;
		logic [4:0] rtc_hour;
		logic [5:0] rtc_minute;
		logic [5:0] rtc_second;
	} item_t;

	typedef struct packed {
		logic       rtc_load;
		logic       rtc_running;
		logic       buzzer_on;
		logic       led_on;
		logic       alarm_sounding;
		logic       blink_phase;
		logic [5:0] shown_second;
		logic [5:0] shown_minute;
		logic [4:0] shown_hour;
		logic [1:0] cursor;
		mode_t      view_mode;
	} result_t;

endpackage

@@ hw/rtl/ckas_cfg.sv @@
// ----------------------------------------------------------------------------
// ckas_cfg
// APB register file: blink period, alarm toggle period and alarm length.
// ----------------------------------------------------------------------------
module ckas_cfg
	import ckas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_period <= RST_BLINK_PERIOD;
			cfg_q.alarm_toggle <= RST_ALARM_TOGGLE;
			cfg_q.alarm_length <= RST_ALARM_LENGTH;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BLINK_PERIOD: cfg_q.blink_period <= pwdata[7:0];
				REG_ALARM_TOGGLE: cfg_q.alarm_toggle <= pwdata[7:0];
				REG_ALARM_LENGTH: cfg_q.alarm_length <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BLINK_PERIOD: prdata = {24'd0, cfg_q.blink_period};
			REG_ALARM_TOGGLE: prdata = {24'd0, cfg_q.alarm_toggle};
			REG_ALARM_LENGTH: prdata = {22'd0, cfg_q.alarm_length};
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/ckas_core.sv @@
// ----------------------------------------------------------------------------
// ckas_core
// Controller state and the single-pass update for one key sample or tick.
// ----------------------------------------------------------------------------
module ckas_core
	import ckas_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t      mode_q, mode_d;
	logic [1:0] cursor_q, cursor_d;
	logic [4:0] edit_hour_q, edit_hour_d, alarm_hour_q, alarm_hour_d;
	logic [5:0] edit_min_q, edit_min_d, alarm_min_q, alarm_min_d;
	logic [5:0] edit_sec_q, edit_sec_d, alarm_sec_q, alarm_sec_d;
	logic [7:0] prev_key_q, prev_key_d;
	logic [7:0] blink_cnt_q, blink_cnt_d, blink_sum;
	logic       blink_q, blink_d;
	logic       alarm_on_q, alarm_on_d;
	logic [9:0] elapsed_q, elapsed_d;
	logic [7:0] toggle_cnt_q, toggle_cnt_d, toggle_sum;
	logic       led_q, led_d, buzzer_q, buzzer_d;
	logic       run_q, run_d;
	logic       load;
	logic [7:0] press;
	logic       step_up, step_en, on_edit;
	logic       alarm_match;

	function automatic logic [5:0] step_value(input logic [5:0] v, input logic [5:0] lim,
			input logic up);
		logic [5:0] r;
		if (up) begin
			r = (v >= lim) ? 6'd0 : v + 6'd1;
		end else begin
			r = (v == 6'd0) ? lim : v - 6'd1;
		end
		return r;
	endfunction

	always_comb begin
		mode_d       = mode_q;
		cursor_d     = cursor_q;
		edit_hour_d  = edit_hour_q;
		edit_min_d   = edit_min_q;
		edit_sec_d   = edit_sec_q;
		alarm_hour_d = alarm_hour_q;
		alarm_min_d  = alarm_min_q;
		alarm_sec_d  = alarm_sec_q;
		prev_key_d   = prev_key_q;
		blink_cnt_d  = blink_cnt_q;
		blink_d      = blink_q;
		alarm_on_d   = alarm_on_q;
		elapsed_d    = elapsed_q;
		toggle_cnt_d = toggle_cnt_q;
		led_d        = led_q;
		buzzer_d     = buzzer_q;
		run_d        = run_q;
		load         = 1'b0;
		press        = '0;
		step_en      = 1'b0;
		step_up      = 1'b0;
		on_edit      = (mode_q == MODE_SET_CLOCK);
		alarm_match  = 1'b0;
		blink_sum    = blink_cnt_q + 8'd1;
		toggle_sum   = toggle_cnt_q + 8'd1;

		if (!item.command) begin
			press      = item.key_code & ~prev_key_q;
			prev_key_d = item.key_code;
			if (press != 8'd0) begin
				if (mode_q == MODE_CLOCK || mode_q == MODE_TEMP) begin
					case (press)
						KEY_DEC: mode_d = (mode_q == MODE_CLOCK) ? MODE_TEMP : MODE_CLOCK;
						KEY_SET_CLOCK: begin
							mode_d      = MODE_SET_CLOCK;
							cursor_d    = CUR_HOUR;
							run_d       = 1'b0;
							edit_hour_d = item.rtc_hour;
							edit_min_d  = item.rtc_minute;
							edit_sec_d  = item.rtc_second;
						end
						KEY_SET_ALARM: begin
							mode_d   = MODE_SET_ALARM;
							cursor_d = CUR_HOUR;
						end
						default: ;
					endcase
				end else begin
					case (press) inside
						KEY_SET_CLOCK, KEY_SET_ALARM: begin
							if (cursor_q < CUR_SECOND) begin
								cursor_d = cursor_q + 2'd1;
							end else begin
								mode_d   = MODE_CLOCK;
								cursor_d = CUR_HOUR;
								if (press == KEY_SET_CLOCK && on_edit) begin
									load  = 1'b1;
									run_d = 1'b1;
								end
							end
						end
						KEY_UP: begin
							step_en = 1'b1;
							step_up = 1'b1;
						end
						KEY_DEC: step_en = 1'b1;
						default: ;
					endcase
				end
			end

			if (step_en) begin
				if (cursor_q == CUR_HOUR) begin
					if (on_edit) begin
						edit_hour_d = 5'(step_value({1'b0, edit_hour_q}, HOUR_MAX, step_up));
					end else begin
						alarm_hour_d = 5'(step_value({1'b0, alarm_hour_q}, HOUR_MAX, step_up));
					end
				end else if (cursor_q == CUR_MINUTE) begin
					if (on_edit) begin
						edit_min_d = step_value(edit_min_q, MIN_MAX, step_up);
					end else begin
						alarm_min_d = step_value(alarm_min_q, MIN_MAX, step_up);
					end
				end else begin
					if (on_edit) begin
						edit_sec_d = step_value(edit_sec_q, MIN_MAX, step_up);
					end else begin
						alarm_sec_d = step_value(alarm_sec_q, MIN_MAX, step_up);
					end
				end
			end

			alarm_match = (item.rtc_hour == alarm_hour_d) && (item.rtc_minute == alarm_min_d)
				&& (item.rtc_second == alarm_sec_d);
			if (!alarm_on_q && alarm_match) begin
				alarm_on_d   = 1'b1;
				elapsed_d    = '0;
				toggle_cnt_d = '0;
				led_d        = 1'b1;
				buzzer_d     = 1'b1;
			end
			if (alarm_on_d && press != 8'd0) begin
				alarm_on_d = 1'b0;
				led_d      = 1'b0;
				buzzer_d   = 1'b0;
			end
		end else begin
			blink_cnt_d = blink_sum;
			if (blink_sum >= cfg.blink_period) begin
				blink_cnt_d = '0;
				blink_d     = ~blink_q;
			end
			if (alarm_on_q) begin
				elapsed_d    = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 10'd1 : elapsed_q;
				toggle_cnt_d = toggle_sum;
				if (toggle_sum >= cfg.alarm_toggle) begin
					toggle_cnt_d = '0;
					led_d        = ~led_q;
					buzzer_d     = ~buzzer_q;
				end
				if (elapsed_d >= cfg.alarm_length) begin
					alarm_on_d   = 1'b0;
					elapsed_d    = '0;
					toggle_cnt_d = '0;
					led_d        = 1'b0;
					buzzer_d     = 1'b0;
				end
			end
		end

		res.view_mode      = mode_d;
		res.cursor         = cursor_d;
		res.blink_phase    = blink_d;
		res.alarm_sounding = alarm_on_d;
		res.led_on         = led_d;
		res.buzzer_on      = buzzer_d;
		res.rtc_running    = run_d;
		res.rtc_load       = load;
		if (mode_d == MODE_SET_CLOCK || load) begin
			res.shown_hour   = edit_hour_d;
			res.shown_minute = edit_min_d;
			res.shown_second = edit_sec_d;
		end else begin
			res.shown_hour   = alarm_hour_d;
			res.shown_minute = alarm_min_d;
			res.shown_second = alarm_sec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_CLOCK;
			cursor_q     <= CUR_HOUR;
			edit_hour_q  <= 5'd23;
			edit_min_q   <= 6'd59;
			edit_sec_q   <= 6'd50;
			alarm_hour_q <= '0;
			alarm_min_q  <= '0;
			alarm_sec_q  <= '0;
			prev_key_q   <= '0;
			blink_cnt_q  <= '0;
			blink_q      <= 1'b0;
			alarm_on_q   <= 1'b0;
			elapsed_q    <= '0;
			toggle_cnt_q <= '0;
			led_q        <= 1'b0;
			buzzer_q     <= 1'b0;
			run_q        <= 1'b1;
		end else if (advance) begin
			mode_q       <= mode_d;
			cursor_q     <= cursor_d;
			edit_hour_q  <= edit_hour_d;
			edit_min_q   <= edit_min_d;
			edit_sec_q   <= edit_sec_d;
			alarm_hour_q <= alarm_hour_d;
			alarm_min_q  <= alarm_min_d;
			alarm_sec_q  <= alarm_sec_d;
			prev_key_q   <= prev_key_d;
			blink_cnt_q  <= blink_cnt_d;
			blink_q      <= blink_d;
			alarm_on_q   <= alarm_on_d;
			elapsed_q    <= elapsed_d;
			toggle_cnt_q <= toggle_cnt_d;
			led_q        <= led_d;
			buzzer_q     <= buzzer_d;
			run_q        <= run_d;
		end
	end

	a_led_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		!alarm_on_q |-> (!led_q && !buzzer_q))
		else $error("led or buzzer active without alarm");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != 2'd3)
		else $error("cursor out of range");

	a_cursor_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q != CUR_HOUR |-> (mode_q == MODE_SET_CLOCK || mode_q == MODE_SET_ALARM))
		else $error("cursor moved outside a set mode");

	a_load_exits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && load) |=> (mode_q == MODE_CLOCK && run_q))
		else $error("rtc load without return to clock view");

endmodule

@@ hw/rtl/clock_alarm_set_controller_top.sv @@
// ----------------------------------------------------------------------------
// clock_alarm_set_controller_top
// Alarm clock setting controller: key handling, alarm match and tick timing.
//
// Input stream s_*: one request per key scan sample (s_tuser 0) or 50 ms
// tick (s_tuser 1), carrying the raw key code and the live RTC time.
// Output stream m_*: exactly one result per request, in order, with view
// mode, cursor, shown time, blink phase, alarm drives and RTC control.
// APB port: blink period (0x0), alarm toggle period (0x4), alarm length
// (0x8); write only while the block is idle.
// Path: m_tvalid rises once an accepted request has passed the input
// register and then the result register. Throughput: one request per
// cycle while m_tready is high or the result register is empty.
// Reset: clock view, RTC running, edit buffer 23:59:50, alarm 00:00:00,
// registers at 10, 4 and 100 ticks; both streams empty.
// Stall: while m_tready is low the result holds, the input register fills
// and s_tready drops once it is occupied; no request is lost.
// ----------------------------------------------------------------------------
module clock_alarm_set_controller_top
	import ckas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // key_code, rtc_hour, rtc_minute, rtc_second
	input  logic                  s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // view_mode, cursor, shown_hour, shown_minute,
	                                        // shown_second, blink_phase, alarm_sounding,
	                                        // led_on, buzzer_on, rtc_running, rtc_load
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t res_s2;
	logic    valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command    <= s_tuser;
			item_s1.key_code   <= s_tdata[7:0];
			item_s1.rtc_hour   <= s_tdata[12:8];
			item_s1.rtc_minute <= s_tdata[18:13];
			item_s1.rtc_second <= s_tdata[24:19];
		end
	end

	ckas_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ckas_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_s2};

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("pending request dropped from input register");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed request produced no result");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("request accepted while both stages are blocked");

endmodule
